>>> sv/exposure_smoothing_meter_top_defines.svh
// assertion macros for the exposure smoothing meter
`ifndef EXPOSURE_SMOOTHING_METER_TOP_DEFINES_SVH
`define EXPOSURE_SMOOTHING_METER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define ESM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ESM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/esm_pkg.sv
// shared types and constants of the exposure smoothing meter
package esm_pkg;

  localparam int LUX_W      = 24;
  localparam int RES_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int MUL_A_W = 40;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 72;
  localparam int REM_W   = 40;
  localparam int SUB_W   = REM_W + 1;
  localparam int DVD_W   = 64;
  localparam int ROOT_W  = 32;
  localparam int CNT_W   = 7;
  localparam int STEP_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_APERTURE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHUTTER  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ISO      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CALIB_K  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT    = 3'd6;

  localparam logic MODE_SHUTTER  = 1'b0;
  localparam logic MODE_APERTURE = 1'b1;

  localparam logic [15:0] APERTURE_RST = 16'd2048;
  localparam logic [31:0] SHUTTER_RST  = 32'd65536;
  localparam logic [15:0] ISO_RST      = 16'd100;
  localparam logic [15:0] CALIB_K_RST  = 16'd5120;
  localparam logic [16:0] ALPHA_RST    = 17'd32768;
  localparam logic [4:0]  COUNT_RST    = 5'd8;

  localparam logic [RES_W-1:0]   SAT32   = 32'hFFFF_FFFF;
  localparam logic [MUL_B_W-1:0] ONE_Q16 = 17'h1_0000;

  localparam logic [STEP_W-1:0] STEP0 = 3'd0;
  localparam logic [STEP_W-1:0] STEP1 = 3'd1;
  localparam logic [STEP_W-1:0] STEP2 = 3'd2;
  localparam logic [STEP_W-1:0] STEP3 = 3'd3;
  localparam logic [STEP_W-1:0] STEP4 = 3'd4;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b000_0001,
    S_MUL    = 7'b000_0010,
    S_DIV    = 7'b000_0100,
    S_SQRT   = 7'b000_1000,
    S_SMOOTH = 7'b001_0000,
    S_MEAN   = 7'b010_0000,
    S_OUT    = 7'b100_0000
  } esm_state_t;

endpackage

>>> sv/esm_in_if.sv
// lux sample channel
interface esm_in_if;
  import esm_pkg::*;

  logic             valid;
  logic             ready;
  logic [LUX_W-1:0] lux_sample;

  modport source (output valid, output lux_sample, input ready);
  modport sink (input valid, input lux_sample, output ready);
endinterface

>>> sv/esm_out_if.sv
// exposure result channel
interface esm_out_if;
  import esm_pkg::*;

  logic             valid;
  logic             ready;
  logic [RES_W-1:0] exposure_result;
  logic             saturated;

  modport source (output valid, output exposure_result, output saturated, input ready);
  modport sink (input valid, input exposure_result, input saturated, output ready);
endinterface

>>> sv/exposure_smoothing_meter_top.sv
// exposure smoothing meter: lux samples in, mean smoothed exposure out
// in_bus takes one lux sample per beat; out_bus gives one result beat after
// every sample_count samples; cfg_we/cfg_index/cfg_data write settings, which
// the user must write only while idle; the block itself does not enforce this.
// in_bus.ready is high only in the idle state. steps on one shared multiplier
// and one shared compare-subtract work through each accepted beat:
//   shutter mode:  4 multiply steps + 32 divide steps + 1 or 3 smoothing steps
//   aperture mode: 5 multiply steps + 64 divide steps + 32 root steps + 1 or 3
//   a saturated sample skips the divide and root steps
//   last sample of a measurement adds 32 + clog2(MAX_SAMPLES + 1) mean steps
//   and then the output state loads the output register.
// the result sits in an output register; the next samples are taken while it
// waits. if it is still not taken when the next result is ready, the block
// holds in its output state with in_bus.ready low until out_bus.ready.
// reset (synchronous, rst_n low) restores the default settings, clears the
// running measurement and drops out_bus.valid.
`include "exposure_smoothing_meter_top_defines.svh"

module exposure_smoothing_meter_top #(
  parameter int MAX_SAMPLES = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  esm_in_if.sink                           in_bus,
  esm_out_if.source                        out_bus,
  input  logic                             cfg_we,
  input  logic [esm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [esm_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import esm_pkg::*;

  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int SW = RES_W + CW;

  // settings
  logic        mode_r;
  logic [15:0] aperture_r;
  logic [31:0] shutter_r;
  logic [15:0] iso_r;
  logic [15:0] calk_r;
  logic [16:0] alpha_r;
  logic [4:0]  scount_r;

  // sequencer and measurement state
  esm_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [SW-1:0]     sum_r, sum_nxt;
  logic [RES_W-1:0]  prev_raw_r, prev_raw_nxt;
  logic [RES_W-1:0]  prev_sm_r, prev_sm_nxt;
  logic              sticky_r, sticky_nxt;
  logic              out_valid_r, out_valid_nxt;

  // datapath
  logic [LUX_W-1:0]  lux_r, lux_nxt;
  logic [RES_W-1:0]  raw_r, raw_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [DVD_W-1:0]  dvd_r, dvd_nxt;
  logic [REM_W-1:0]  dsr_r, dsr_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [RES_W-1:0]  out_result_r;
  logic              out_sat_r;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [SUB_W-1:0]   sub_a, sub_b, sub_diff;
  logic               sub_ge;
  logic [ACC_W-1:0]   add_b, add_sum;
  logic [MUL_B_W-1:0] alpha_c;
  logic [CW-1:0]      count_c;
  logic [CW-1:0]      idx_inc;
  logic [RES_W-1:0]   smooth_val;
  logic [SW-1:0]      sum_add;
  logic               shutter_mode;
  logic               decide;
  logic               smooth_done;
  logic               out_load;
  logic [REM_W-1:0]   root_dbl;

  assign shutter_mode = (mode_r == MODE_SHUTTER);
  assign alpha_c      = (alpha_r > ONE_Q16) ? ONE_Q16 : alpha_r;

  always_comb begin
    if (scount_r == 5'd0) begin
      count_c = CW'(1);
    end else if (32'(scount_r) > 32'(MAX_SAMPLES)) begin
      count_c = CW'(MAX_SAMPLES);
    end else begin
      count_c = CW'(scount_r);
    end
  end

  assign idx_inc = idx_r + CW'(1);

  // shared multiplier, registered
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MUL: begin
        if (shutter_mode) begin
          case (step_r)
            STEP0: begin
              mul_a = MUL_A_W'(aperture_r);
              mul_b = MUL_B_W'(aperture_r);
            end
            STEP1: begin
              mul_a = MUL_A_W'(prod_r[31:0]);
              mul_b = MUL_B_W'(calk_r);
            end
            STEP2: begin
              mul_a = MUL_A_W'(lux_r);
              mul_b = MUL_B_W'(iso_r);
            end
            default: ;
          endcase
        end else begin
          case (step_r)
            STEP0: begin
              mul_a = MUL_A_W'(lux_r);
              mul_b = MUL_B_W'(iso_r);
            end
            STEP1: begin
              mul_a = prod_r[MUL_A_W-1:0];
              mul_b = MUL_B_W'(shutter_r[15:0]);
            end
            STEP2: begin
              mul_a = dsr_r;
              mul_b = MUL_B_W'(shutter_r[31:16]);
            end
            default: ;
          endcase
        end
      end
      S_SMOOTH: begin
        case (step_r)
          STEP0: begin
            mul_a = MUL_A_W'(prev_raw_r);
            mul_b = alpha_c;
          end
          STEP1: begin
            mul_a = MUL_A_W'(prev_sm_r);
            mul_b = ONE_Q16 - alpha_c;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign prod_nxt = {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};

  // shared wide adder
  assign add_b   = (state_r == S_MUL) ? {prod_r[55:0], 16'b0} : {15'b0, prod_r};
  assign add_sum = acc_r + add_b;

  // shared compare-subtract
  always_comb begin
    sub_a = '0;
    sub_b = '0;
    case (state_r)
      S_MUL: begin
        if (shutter_mode) begin
          sub_a = {25'b0, acc_r[47:32]};
          sub_b = {1'b0, prod_r[39:0]};
        end else begin
          sub_a = {17'b0, acc_r[71:48]};
          sub_b = {25'b0, calk_r};
        end
      end
      S_DIV, S_MEAN: begin
        sub_a = {rem_r, dvd_r[DVD_W-1]};
        sub_b = {1'b0, dsr_r};
      end
      S_SQRT: begin
        sub_a = {rem_r[REM_W-2:0], dvd_r[DVD_W-1:DVD_W-2]};
        sub_b = {7'b0, root_r, 2'b01};
      end
      default: ;
    endcase
  end

  assign sub_ge   = (sub_a >= sub_b);
  assign sub_diff = sub_a - sub_b;

  assign decide      = shutter_mode ? (step_r == STEP3) : (step_r == STEP4);
  assign smooth_val  = (idx_r == '0) ? raw_r : add_sum[47:16];
  assign smooth_done = ((step_r == STEP0) && (idx_r == '0)) || (step_r == STEP2);
  assign sum_add     = sum_r + SW'(smooth_val);
  assign out_load    = (state_r == S_OUT) && (!out_valid_r || out_bus.ready);
  assign root_dbl    = {7'b0, root_r, 1'b0};

  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    cnt_nxt      = cnt_r;
    idx_nxt      = idx_r;
    sum_nxt      = sum_r;
    prev_raw_nxt = prev_raw_r;
    prev_sm_nxt  = prev_sm_r;
    sticky_nxt   = sticky_r;
    lux_nxt      = lux_r;
    raw_nxt      = raw_r;
    acc_nxt      = acc_r;
    rem_nxt      = rem_r;
    dvd_nxt      = dvd_r;
    dsr_nxt      = dsr_r;
    root_nxt     = root_r;
    case (state_r)
      S_IDLE: begin
        if (in_bus.valid) begin
          lux_nxt   = in_bus.lux_sample;
          step_nxt  = STEP0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP1 && !shutter_mode) begin
          dsr_nxt = prod_r[MUL_A_W-1:0];
        end
        if (step_r == STEP2) begin
          acc_nxt = ACC_W'(prod_r);
        end
        if (step_r == STEP3 && !shutter_mode) begin
          acc_nxt = add_sum;
        end
        if (decide) begin
          if (sub_ge) begin
            sticky_nxt = 1'b1;
            raw_nxt    = SAT32;
            step_nxt   = STEP0;
            state_nxt  = S_SMOOTH;
          end else if (shutter_mode) begin
            rem_nxt   = sub_a[REM_W-1:0];
            dvd_nxt   = {acc_r[31:0], 32'b0};
            dsr_nxt   = prod_r[REM_W-1:0];
            cnt_nxt   = CNT_W'(32);
            state_nxt = S_DIV;
          end else begin
            rem_nxt   = sub_a[REM_W-1:0];
            dvd_nxt   = {acc_r[47:0], 16'b0};
            dsr_nxt   = {24'b0, calk_r};
            cnt_nxt   = CNT_W'(64);
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        rem_nxt = sub_ge ? sub_diff[REM_W-1:0] : sub_a[REM_W-1:0];
        dvd_nxt = {dvd_r[DVD_W-2:0], sub_ge};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          if (shutter_mode) begin
            raw_nxt   = {dvd_r[RES_W-2:0], sub_ge};
            step_nxt  = STEP0;
            state_nxt = S_SMOOTH;
          end else begin
            rem_nxt   = '0;
            root_nxt  = '0;
            cnt_nxt   = CNT_W'(ROOT_W);
            state_nxt = S_SQRT;
          end
        end
      end
      S_SQRT: begin
        rem_nxt  = sub_ge ? sub_diff[REM_W-1:0] : sub_a[REM_W-1:0];
        dvd_nxt  = {dvd_r[DVD_W-3:0], 2'b00};
        root_nxt = {root_r[ROOT_W-2:0], sub_ge};
        cnt_nxt  = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          raw_nxt   = {root_r[ROOT_W-2:0], sub_ge};
          step_nxt  = STEP0;
          state_nxt = S_SMOOTH;
        end
      end
      S_SMOOTH: begin
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP1) begin
          acc_nxt = ACC_W'(prod_r);
        end
        if (smooth_done) begin
          sum_nxt      = sum_add;
          prev_raw_nxt = raw_r;
          prev_sm_nxt  = smooth_val;
          idx_nxt      = idx_inc;
          if (idx_inc >= count_c) begin
            rem_nxt   = '0;
            dvd_nxt   = {sum_add, {(DVD_W - SW){1'b0}}};
            dsr_nxt   = REM_W'(count_c);
            cnt_nxt   = CNT_W'(SW);
            state_nxt = S_MEAN;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_MEAN: begin
        rem_nxt = sub_ge ? sub_diff[REM_W-1:0] : sub_a[REM_W-1:0];
        dvd_nxt = {dvd_r[DVD_W-2:0], sub_ge};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          idx_nxt      = '0;
          sum_nxt      = '0;
          prev_raw_nxt = '0;
          prev_sm_nxt  = '0;
          sticky_nxt   = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= STEP0;
      cnt_r       <= '0;
      idx_r       <= '0;
      sum_r       <= '0;
      prev_raw_r  <= '0;
      prev_sm_r   <= '0;
      sticky_r    <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= MODE_SHUTTER;
      aperture_r  <= APERTURE_RST;
      shutter_r   <= SHUTTER_RST;
      iso_r       <= ISO_RST;
      calk_r      <= CALIB_K_RST;
      alpha_r     <= ALPHA_RST;
      scount_r    <= COUNT_RST;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      sum_r       <= sum_nxt;
      prev_raw_r  <= prev_raw_nxt;
      prev_sm_r   <= prev_sm_nxt;
      sticky_r    <= sticky_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE:     mode_r     <= cfg_data[0];
          REG_APERTURE: aperture_r <= cfg_data[15:0];
          REG_SHUTTER:  shutter_r  <= cfg_data[31:0];
          REG_ISO:      iso_r      <= cfg_data[15:0];
          REG_CALIB_K:  calk_r     <= cfg_data[15:0];
          REG_ALPHA:    alpha_r    <= cfg_data[16:0];
          REG_COUNT:    scount_r   <= cfg_data[4:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    lux_r  <= lux_nxt;
    raw_r  <= raw_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    rem_r  <= rem_nxt;
    dvd_r  <= dvd_nxt;
    dsr_r  <= dsr_nxt;
    root_r <= root_nxt;
    if (out_load) begin
      out_result_r <= dvd_r[RES_W-1:0];
      out_sat_r    <= sticky_r;
    end
  end

  assign in_bus.ready            = (state_r == S_IDLE);
  assign out_bus.valid           = out_valid_r;
  assign out_bus.exposure_result = out_result_r;
  assign out_bus.saturated       = out_sat_r;

  `ESM_ASSERT_IMPL(a_div_rem_below_dsr, state_r == S_DIV || state_r == S_MEAN, rem_r < dsr_r, "divider remainder not below divisor")
  `ESM_ASSERT_IMPL(a_sqrt_rem_bound, state_r == S_SQRT, rem_r <= root_dbl, "root remainder above twice the partial root")
  `ESM_ASSERT_NEXT(a_meas_cleared, out_load, idx_r == '0 && sum_r == '0 && !sticky_r && prev_raw_r == '0, "measurement state not cleared after result")
  `ESM_ASSERT_IMPL(a_idle_index, state_r == S_IDLE, idx_r < CW'(MAX_SAMPLES), "sample index out of range while idle")

endmodule
